FILE: design/obpl_pkg.sv
// ---------------------------------------------------------------------------
// obpl_pkg
// Shared constants, codes and types of the order book price level block.
// ---------------------------------------------------------------------------
`default_nettype none

package obpl_pkg;

  localparam int ORDER_SLOTS_DEF = 1024;
  localparam int LEVELS_DEF      = 64;

  localparam int ID_W    = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int LQTY_W  = 40;
  localparam int MID_W   = 33;

  localparam logic [LQTY_W-1:0] LQTY_MAX = {LQTY_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_UNKNOWN    = 2'd1,
    STS_ORDER_FULL = 2'd2,
    STS_LEVEL_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LEVEL,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_ADD,
    LOP_SUB
  } lop_kind_t;

  typedef struct packed {
    lop_kind_t          kind;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   amt;
  } lvl_op_t;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [LQTY_W-1:0]  qty;
  } lvl_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    key;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   rem;
  } ord_t;

endpackage

`default_nettype wire

FILE: design/obpl_order_mem.sv
// ---------------------------------------------------------------------------
// obpl_order_mem
// Order record memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module obpl_order_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire obpl_pkg::ord_t       wdata,
  input  wire logic [ADDR_W-1:0]    raddr,
  output obpl_pkg::ord_t            rdata_r
);
  import obpl_pkg::*;

  ord_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/obpl_level_cell.sv
// ---------------------------------------------------------------------------
// obpl_level_cell
// One price level of a sorted side; shifts toward or away from the best end.
// ---------------------------------------------------------------------------
`default_nettype none

module obpl_level_cell #(
  parameter bit IS_ASK = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire obpl_pkg::lvl_op_t op,
  input  wire logic            any_match,
  input  wire logic            any_rm,
  input  wire logic            prev_ahead,
  input  wire obpl_pkg::lvl_t  prev,
  input  wire obpl_pkg::lvl_t  next,
  output obpl_pkg::lvl_t       cur_r,
  output logic                 ahead,
  output logic                 match,
  output logic                 rm
);
  import obpl_pkg::*;

  lvl_t               cur_nxt;
  logic [LQTY_W:0]    sum;
  logic [LQTY_W-1:0]  amt_ext;

  assign amt_ext = {{(LQTY_W-QTY_W){1'b0}}, op.amt};
  assign sum     = {1'b0, cur_r.qty} + {1'b0, amt_ext};
  assign ahead   = cur_r.valid &&
                   (IS_ASK ? (cur_r.price < op.price) : (cur_r.price > op.price));
  assign match   = cur_r.valid && (cur_r.price == op.price);
  assign rm      = match && (cur_r.qty <= amt_ext);

  always_comb begin
    cur_nxt = cur_r;
    unique case (op.kind)
      LOP_ADD: begin
        if (any_match) begin
          if (match) begin
            cur_nxt.qty = sum[LQTY_W] ? LQTY_MAX : sum[LQTY_W-1:0];
          end
        end else if (!ahead) begin
          if (prev_ahead) begin
            cur_nxt.valid = 1'b1;
            cur_nxt.price = op.price;
            cur_nxt.qty   = amt_ext;
          end else begin
            cur_nxt = prev;
          end
        end
      end
      LOP_SUB: begin
        if (any_rm) begin
          if (!ahead) begin
            cur_nxt = next;
          end
        end else if (match) begin
          cur_nxt.qty = cur_r.qty - amt_ext;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r.price <= cur_nxt.price;
    cur_r.qty   <= cur_nxt.qty;
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r.valid <= cur_nxt.valid;
    end
  end

endmodule

`default_nettype wire

FILE: design/obpl_level_side.sv
// ---------------------------------------------------------------------------
// obpl_level_side
// Chain of level cells for one side, kept packed and sorted best first.
// ---------------------------------------------------------------------------
`default_nettype none

module obpl_level_side #(
  parameter int LEVELS = 64,
  parameter bit IS_ASK = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire obpl_pkg::lvl_op_t op,
  output obpl_pkg::lvl_t         best,
  output logic                   any_match,
  output logic                   full
);
  import obpl_pkg::*;

  lvl_t             cells [LEVELS];
  logic [LEVELS-1:0] ahead_v;
  logic [LEVELS-1:0] match_v;
  logic [LEVELS-1:0] rm_v;
  logic              any_rm;

  assign any_match = |match_v;
  assign any_rm    = |rm_v;
  assign best      = cells[0];
  assign full      = cells[LEVELS-1].valid;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    lvl_t prev_c;
    lvl_t next_c;
    logic prev_a;

    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_a = 1'b1;
    end else begin : g_body
      assign prev_c = cells[i-1];
      assign prev_a = ahead_v[i-1];
    end

    if (i == LEVELS - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    obpl_level_cell #(
      .IS_ASK(IS_ASK)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .any_match (any_match),
      .any_rm    (any_rm),
      .prev_ahead(prev_a),
      .prev      (prev_c),
      .next      (next_c),
      .cur_r     (cells[i]),
      .ahead     (ahead_v[i]),
      .match     (match_v[i]),
      .rm        (rm_v[i])
    );
  end

endmodule

`default_nettype wire

FILE: design/order_book_price_levels_top.sv
// ---------------------------------------------------------------------------
// order_book_price_levels_top
// A command is registered on transfer, ST_SCAN reads the order table until
// the id is found or the last slot is read, ST_LEVEL updates the levels and
// ST_RESP loads the result register. Throughput: one command at a time, set
// by the order table scan, which reads one entry per cycle through the
// single memory read port. Reset: levels clear at once; a clearing pass runs
// over the order memory before the first input transfer is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module order_book_price_levels_top #(
  parameter int ORDER_SLOTS     = obpl_pkg::ORDER_SLOTS_DEF,
  parameter int LEVELS_PER_SIDE = obpl_pkg::LEVELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_command,
  input  wire logic [obpl_pkg::ID_W-1:0]     in_order_id,
  input  wire logic                          in_side,
  input  wire logic [obpl_pkg::PRICE_W-1:0]  in_price,
  input  wire logic [obpl_pkg::QTY_W-1:0]    in_quantity,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic                               out_fully_filled,
  output logic                               out_bid_valid,
  output logic [obpl_pkg::PRICE_W-1:0]       out_best_bid_price,
  output logic [obpl_pkg::LQTY_W-1:0]        out_best_bid_qty,
  output logic                               out_ask_valid,
  output logic [obpl_pkg::PRICE_W-1:0]       out_best_ask_price,
  output logic [obpl_pkg::LQTY_W-1:0]        out_best_ask_qty,
  output logic [obpl_pkg::MID_W-1:0]         out_mid_half_ticks
);
  import obpl_pkg::*;

  localparam int ADDR_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(ORDER_SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  cmd_t               cmd_r;
  logic [ID_W-1:0]    id_r;
  logic               side_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;
  logic [ADDR_W-1:0]  scan_addr_r;
  logic [ADDR_W-1:0]  chk_addr_r;
  logic               chk_vld_r;
  logic               hit_r;
  logic [ADDR_W-1:0]  slot_r;
  logic               free_vld_r;
  logic [ADDR_W-1:0]  free_slot_r;
  ord_t               ord_r;
  status_t            status_r, status_nxt;
  logic               full_r, full_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_full_r;
  logic               out_bv_r, out_av_r;
  logic [PRICE_W-1:0] out_bp_r, out_ap_r;
  logic [LQTY_W-1:0]  out_bq_r, out_aq_r;
  logic [MID_W-1:0]   out_mid_r;

  ord_t               rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  ord_t               mem_wdata;

  lvl_op_t            bid_op, ask_op;
  lvl_t               bid_best, ask_best;
  logic               bid_match, ask_match, bid_full, ask_full;

  logic               chk_hit, chk_free, chk_last, load_out;

  assign chk_hit  = chk_vld_r && rdata_r.valid && (rdata_r.key == id_r);
  assign chk_free = chk_vld_r && !rdata_r.valid;
  assign chk_last = chk_vld_r && (chk_addr_r == LAST_SLOT);
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  obpl_order_mem #(
    .DEPTH (ORDER_SLOTS),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (scan_addr_r),
    .rdata_r(rdata_r)
  );

  obpl_level_side #(
    .LEVELS(LEVELS_PER_SIDE),
    .IS_ASK(1'b0)
  ) u_bid (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (bid_op),
    .best     (bid_best),
    .any_match(bid_match),
    .full     (bid_full)
  );

  obpl_level_side #(
    .LEVELS(LEVELS_PER_SIDE),
    .IS_ASK(1'b1)
  ) u_ask (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (ask_op),
    .best     (ask_best),
    .any_match(ask_match),
    .full     (ask_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic               op_side;
    logic [PRICE_W-1:0] op_price;
    logic [QTY_W-1:0]   op_amt;
    logic               sel_match;
    logic               sel_full;
    logic               apply;
    lop_kind_t          kind;

    state_nxt  = state_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr_r;
    mem_wdata  = '0;
    status_nxt = STS_OK;
    full_nxt   = 1'b0;
    apply      = 1'b0;
    kind       = LOP_NONE;

    op_side   = (cmd_r == CMD_ADD) ? side_r : ord_r.side;
    op_price  = (cmd_r == CMD_ADD) ? price_r : ord_r.price;
    op_amt    = (cmd_r == CMD_CANCEL) ? ord_r.rem : qty_r;
    bid_op    = '{kind: LOP_NONE, price: op_price, amt: op_amt};
    ask_op    = '{kind: LOP_NONE, price: op_price, amt: op_amt};
    sel_match = op_side ? ask_match : bid_match;
    sel_full  = op_side ? ask_full : bid_full;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = (cmd_t'(in_command) == CMD_NOP) ? ST_LEVEL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_hit || chk_last) begin
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        state_nxt = ST_RESP;
        unique case (cmd_r)
          CMD_ADD: begin
            if (!hit_r && !free_vld_r) begin
              status_nxt = STS_ORDER_FULL;
            end else if (!sel_match && sel_full) begin
              status_nxt = STS_LEVEL_FULL;
            end else begin
              apply     = 1'b1;
              kind      = LOP_ADD;
              mem_we    = 1'b1;
              mem_waddr = hit_r ? slot_r : free_slot_r;
              mem_wdata = '{valid: 1'b1, key: id_r, side: side_r,
                            price: price_r, rem: qty_r};
            end
          end
          CMD_CANCEL, CMD_FILL: begin
            if (!hit_r) begin
              status_nxt = STS_UNKNOWN;
            end else begin
              apply     = 1'b1;
              kind      = LOP_SUB;
              mem_we    = 1'b1;
              mem_waddr = slot_r;
              mem_wdata = ord_r;
              if (cmd_r == CMD_CANCEL || qty_r >= ord_r.rem) begin
                mem_wdata.valid = 1'b0;
                full_nxt        = (cmd_r == CMD_FILL);
              end else begin
                mem_wdata.rem = ord_r.rem - qty_r;
              end
            end
          end
          default: begin
            status_nxt = STS_OK;
          end
        endcase
        if (apply) begin
          if (op_side) begin
            ask_op.kind = kind;
          end else begin
            bid_op.kind = kind;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r       <= cmd_t'(in_command);
      id_r        <= in_order_id;
      side_r      <= in_side;
      price_r     <= in_price;
      qty_r       <= in_quantity;
      scan_addr_r <= '0;
      chk_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_vld_r  <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      scan_addr_r <= scan_addr_r + 1'b1;
      chk_addr_r  <= scan_addr_r;
      chk_vld_r   <= 1'b1;
      if (chk_hit) begin
        hit_r  <= 1'b1;
        slot_r <= chk_addr_r;
        ord_r  <= rdata_r;
      end
      if (chk_free && !free_vld_r) begin
        free_vld_r  <= 1'b1;
        free_slot_r <= chk_addr_r;
      end
    end
    if (state_r == ST_LEVEL) begin
      status_r <= status_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_full_r   <= full_r;
      out_bv_r     <= bid_best.valid;
      out_bp_r     <= bid_best.valid ? bid_best.price : '0;
      out_bq_r     <= bid_best.valid ? bid_best.qty : '0;
      out_av_r     <= ask_best.valid;
      out_ap_r     <= ask_best.valid ? ask_best.price : '0;
      out_aq_r     <= ask_best.valid ? ask_best.qty : '0;
      out_mid_r    <= (bid_best.valid && ask_best.valid) ?
                      ({1'b0, bid_best.price} + {1'b0, ask_best.price}) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_fully_filled   = out_full_r;
  assign out_bid_valid      = out_bv_r;
  assign out_best_bid_price = out_bp_r;
  assign out_best_bid_qty   = out_bq_r;
  assign out_ask_valid      = out_av_r;
  assign out_best_ask_price = out_ap_r;
  assign out_best_ask_qty   = out_aq_r;
  assign out_mid_half_ticks = out_mid_r;

`ifndef SYNTHESIS
  a_level_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LEVEL |=> state_r == ST_RESP)
    else $error("level update not followed by response");

  a_filled_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_status_r == STS_OK)
    else $error("fully filled reported with error status");

  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (!out_bv_r || !out_av_r) |-> out_mid_r == '0)
    else $error("mid price reported with an empty side");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("block idle after taking a command");
`endif

endmodule

`default_nettype wire
